>>> rtl/pidl_pkg.sv
package pidl_pkg;

  localparam int STORE_DEPTH_DEF = 8;
  localparam int CNT_W           = 4;
  localparam int MAX_ENTRIES     = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CAP_RESET = 4'd5;

  typedef enum logic [2:0] {
    MODE_PUSH = 3'd0,
    MODE_POP  = 3'd1,
    MODE_DEQ  = 3'd2,
    MODE_INS  = 3'd3,
    MODE_REM  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0][63:0] name;
    logic [15:0]      qty;
    logic [4:0]       day;
    logic [3:0]       month;
    logic [13:0]      year;
  } record_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage

>>> rtl/positional_insert_delete_list_unit.sv
// channel   signals                                  handshake
// -------   --------------------------------------   ------------------------------
// command   mode position name_word_0..3 quantity    taken when start && !busy
//           expiry_day expiry_month expiry_year
// result    status entry_count out_name_0..3         valid for one cycle with done
//           out_quantity out_day out_month out_year
// config    cfg_we cfg_data (capacity_limit)         written when cfg_we is high
//
// one item per cycle: the result appears with done in the cycle after start
// every cell of the chain shifts in the same cycle, so busy never rises
// synchronous active-high rst clears the count and sets capacity_limit to 5
// record cells hold no reset value and are only read below the count
// the receiver cannot stall; results are never held back
module positional_insert_delete_list_unit #(
  parameter int STORE_DEPTH = pidl_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic [2:0]  mode,
  input  logic [3:0]  position,
  input  logic [63:0] name_word_0,
  input  logic [63:0] name_word_1,
  input  logic [63:0] name_word_2,
  input  logic [63:0] name_word_3,
  input  logic [15:0] quantity,
  input  logic [4:0]  expiry_day,
  input  logic [3:0]  expiry_month,
  input  logic [13:0] expiry_year,
  output logic [1:0]  status,
  output logic [3:0]  entry_count,
  output logic [63:0] out_name_0,
  output logic [63:0] out_name_1,
  output logic [63:0] out_name_2,
  output logic [63:0] out_name_3,
  output logic [15:0] out_quantity,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [13:0] out_year
);

  // the 4-bit count never exceeds 15, so cells past that are never used
  localparam int CELLS = (STORE_DEPTH > pidl_pkg::MAX_ENTRIES) ?
                         pidl_pkg::MAX_ENTRIES : STORE_DEPTH;

  logic                            accept;
  pidl_pkg::cell_ctl_t             ctl;
  pidl_pkg::status_t               status_c;
  logic [pidl_pkg::CNT_W-1:0]      count_next;
  pidl_pkg::record_t               new_rec;
  pidl_pkg::record_t               cell_rec [CELLS];
  pidl_pkg::record_t               removed;
  pidl_pkg::record_t               out_rec;

  // the whole chain shifts together, so busy stays low
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign new_rec.name  = {name_word_3, name_word_2, name_word_1, name_word_0};
  assign new_rec.qty   = quantity;
  assign new_rec.day   = expiry_day;
  assign new_rec.month = expiry_month;
  assign new_rec.year  = expiry_year;

  pidl_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .mode       (mode),
    .position   (position),
    .ctl        (ctl),
    .status     (status_c),
    .count_next (count_next)
  );

  // chain of record cells; cell 0 is the front of the list
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    pidl_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_rec   (new_rec),
      .lower_rec ((i == 0) ? cell_rec[i] : cell_rec[(i == 0) ? 0 : i-1]),
      .upper_rec ((i == CELLS-1) ? cell_rec[i] : cell_rec[(i == CELLS-1) ? i : i+1]),
      .rec       (cell_rec[i])
    );
  end

  // pick the record leaving the list, before the chain shifts
  always_comb begin
    removed = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (ctl.idx == pidl_pkg::CNT_W'(i)) removed = removed | cell_rec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // result registers: payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_c;
      entry_count <= count_next;
      out_rec     <= ctl.rem ? removed : '0;
    end
  end

  assign out_name_0   = out_rec.name[0];
  assign out_name_1   = out_rec.name[1];
  assign out_name_2   = out_rec.name[2];
  assign out_name_3   = out_rec.name[3];
  assign out_quantity = out_rec.qty;
  assign out_day      = out_rec.day;
  assign out_month    = out_rec.month;
  assign out_year     = out_rec.year;

endmodule

>>> rtl/pidl_cell.sv
module pidl_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  pidl_pkg::cell_ctl_t  ctl,
  input  pidl_pkg::record_t    new_rec,
  input  pidl_pkg::record_t    lower_rec,
  input  pidl_pkg::record_t    upper_rec,
  output pidl_pkg::record_t    rec
);

  localparam logic [pidl_pkg::CNT_W:0] ME = (pidl_pkg::CNT_W+1)'(CELL_IDX);

  logic [pidl_pkg::CNT_W:0] idx_x;
  logic [pidl_pkg::CNT_W:0] cnt_x;
  pidl_pkg::record_t        rec_next;

  assign idx_x = {1'b0, ctl.idx};
  assign cnt_x = {1'b0, ctl.count};

  always_comb begin
    rec_next = rec;
    if (ctl.ins) begin
      if (ME == idx_x) begin
        rec_next = new_rec;
      end else if (ME > idx_x && ME <= cnt_x) begin
        rec_next = lower_rec;
      end
    end else if (ctl.rem) begin
      // close the gap: take the neighbor above
      if (ME >= idx_x && ME + 1'b1 < cnt_x) begin
        rec_next = upper_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

>>> rtl/pidl_ctrl.sv
module pidl_ctrl #(
  parameter int STORE_DEPTH = pidl_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pidl_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          accept,
  input  logic [2:0]                    mode,
  input  logic [3:0]                    position,
  output pidl_pkg::cell_ctl_t           ctl,
  output pidl_pkg::status_t             status,
  output logic [pidl_pkg::CNT_W-1:0]    count_next
);

  logic [pidl_pkg::CNT_W-1:0] capacity_limit;
  logic [pidl_pkg::CNT_W-1:0] count;
  logic                       full;
  logic                       empty;
  logic [pidl_pkg::CNT_W:0]   pos_x;
  logic [pidl_pkg::CNT_W:0]   cnt_x;
  logic                       ins_ok;
  logic                       rem_ok;
  logic [pidl_pkg::CNT_W-1:0] idx;

  assign full  = (int'(count) >= int'(capacity_limit)) || (int'(count) >= STORE_DEPTH);
  assign empty = (count == '0);
  assign pos_x = {1'b0, position};
  assign cnt_x = {1'b0, count};

  always_comb begin
    status = pidl_pkg::ST_OK;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    idx    = '0;
    unique case (mode)
      pidl_pkg::MODE_PUSH: begin
        if (full) status = pidl_pkg::ST_FULL;
        else begin
          ins_ok = 1'b1;
          idx    = count;
        end
      end
      pidl_pkg::MODE_INS: begin
        if (full) status = pidl_pkg::ST_FULL;
        else if (pos_x == '0 || pos_x > cnt_x + 1'b1) status = pidl_pkg::ST_BADPOS;
        else begin
          ins_ok = 1'b1;
          idx    = position - 1'b1;
        end
      end
      pidl_pkg::MODE_POP: begin
        if (empty) status = pidl_pkg::ST_EMPTY;
        else begin
          rem_ok = 1'b1;
          idx    = count - 1'b1;
        end
      end
      pidl_pkg::MODE_DEQ: begin
        if (empty) status = pidl_pkg::ST_EMPTY;
        else rem_ok = 1'b1;
      end
      pidl_pkg::MODE_REM: begin
        if (empty) status = pidl_pkg::ST_EMPTY;
        else if (pos_x == '0 || pos_x > cnt_x) status = pidl_pkg::ST_BADPOS;
        else begin
          rem_ok = 1'b1;
          idx    = position - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ins_ok) count_next = count + 1'b1;
    else if (rem_ok) count_next = count - 1'b1;
  end

  assign ctl.ins   = accept && ins_ok;
  assign ctl.rem   = accept && rem_ok;
  assign ctl.idx   = idx;
  assign ctl.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= pidl_pkg::CAP_RESET;
      count          <= '0;
    end else begin
      if (cfg_we) capacity_limit <= cfg_data;
      if (accept) count <= count_next;
    end
  end

endmodule

>>> sim/tb_positional_insert_delete_list_unit.sv
`timescale 1ns / 1ps

module tb_positional_insert_delete_list_unit;

  // run shape
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 3;     // quiet cycles before a capacity write
  localparam int TAIL_CYCLES    = 4;     // extra cycles after the last result
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with nothing moving
  localparam int GAP_PCT        = 14;
  localparam int BURST_FIRST    = 600;   // commands in [first, last) go without gaps
  localparam int BURST_LAST     = 900;
  localparam int PHASE_ITEMS    = 140;
  localparam int ZERO_CAP_ITEMS = 40;

  // modes the block treats as no-ops
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  // one list command as the sender presents it
  typedef struct packed {
    logic [2:0]        mode;
    logic [3:0]        pos;
    pidl_pkg::record_t rec;
  } list_cmd_t;

  // what the block should answer
  typedef struct packed {
    pidl_pkg::status_t status;
    logic [3:0]        count;
    pidl_pkg::record_t rec;
  } list_reply_t;

  typedef enum logic [1:0] {
    OP_CMD,     // present a list command
    OP_CAP,     // write capacity_limit once the block is quiet
    OP_SETTLE   // hold off until every reply has come back
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    list_cmd_t  cmd;
    logic [3:0] cap;
  } sched_op_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  logic cfg_we;
  logic [3:0] cfg_data;
  logic [2:0] mode;
  logic [3:0] position;
  logic [63:0] name_word_0;
  logic [63:0] name_word_1;
  logic [63:0] name_word_2;
  logic [63:0] name_word_3;
  logic [15:0] quantity;
  logic [4:0] expiry_day;
  logic [3:0] expiry_month;
  logic [13:0] expiry_year;
  logic [1:0] status;
  logic [3:0] entry_count;
  logic [63:0] out_name_0;
  logic [63:0] out_name_1;
  logic [63:0] out_name_2;
  logic [63:0] out_name_3;
  logic [15:0] out_quantity;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [13:0] out_year;

  positional_insert_delete_list_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .done(done),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .mode(mode),
    .position(position),
    .name_word_0(name_word_0),
    .name_word_1(name_word_1),
    .name_word_2(name_word_2),
    .name_word_3(name_word_3),
    .quantity(quantity),
    .expiry_day(expiry_day),
    .expiry_month(expiry_month),
    .expiry_year(expiry_year),
    .status(status),
    .entry_count(entry_count),
    .out_name_0(out_name_0),
    .out_name_1(out_name_1),
    .out_name_2(out_name_2),
    .out_name_3(out_name_3),
    .out_quantity(out_quantity),
    .out_day(out_day),
    .out_month(out_month),
    .out_year(out_year)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the list, kept in step with accepted commands
  pidl_pkg::record_t list_mem [0:pidl_pkg::STORE_DEPTH_DEF-1];
  int          list_len = 0;
  logic [3:0]  cap_limit = pidl_pkg::CAP_RESET;
  list_reply_t predicted_replies [$];

  // schedule of commands, capacity writes and hold-offs
  sched_op_t   op_queue [$];
  sched_op_t   head_op;
  list_cmd_t   cur_cmd = '0;
  logic        drv_start;
  logic        drv_we;
  logic        gap_now;
  int          quiet_cycles = 0;

  int n_cmds = 0;
  int n_results = 0;
  int n_cap_writes = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  int status_seen [0:3] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // list behavior
  // ---------------------------------------------------------------------------

  // open a gap at zero-based idx and drop the new record into it
  task automatic list_put(input int idx, input pidl_pkg::record_t rec);
    for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
    list_mem[idx] = rec;
    list_len++;
  endtask

  // pull the record at zero-based idx and close the gap
  task automatic list_take(input int idx, output pidl_pkg::record_t rec);
    rec = list_mem[idx];
    for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endtask

  // update the shadow list for one command and queue the reply it must give
  task automatic apply_list_op(input list_cmd_t c);
    list_reply_t r;
    int lim;
    int pos;
    r = '0;
    r.status = pidl_pkg::ST_OK;
    pos = int'(c.pos);
    // limits above the store depth are capped
    lim = (int'(cap_limit) > pidl_pkg::STORE_DEPTH_DEF) ? pidl_pkg::STORE_DEPTH_DEF :
          int'(cap_limit);
    case (c.mode)
      pidl_pkg::MODE_PUSH, pidl_pkg::MODE_INS: begin
        // full wins over a bad position; a lowered limit keeps extra records
        if (list_len >= lim) r.status = pidl_pkg::ST_FULL;
        else if (c.mode == pidl_pkg::MODE_PUSH) list_put(list_len, c.rec);
        else if (pos < 1 || pos > list_len + 1) r.status = pidl_pkg::ST_BADPOS;
        else list_put(pos - 1, c.rec);
      end
      pidl_pkg::MODE_POP, pidl_pkg::MODE_DEQ, pidl_pkg::MODE_REM: begin
        // empty wins over a bad position
        if (list_len == 0) r.status = pidl_pkg::ST_EMPTY;
        else if (c.mode == pidl_pkg::MODE_POP) list_take(list_len - 1, r.rec);
        else if (c.mode == pidl_pkg::MODE_DEQ) list_take(0, r.rec);
        else if (pos < 1 || pos > list_len) r.status = pidl_pkg::ST_BADPOS;
        else list_take(pos - 1, r.rec);
      end
      default: ;  // unused modes leave the list alone
    endcase
    r.count = 4'(list_len);
    predicted_replies.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: reply %0d %s: got %h, want %h", $time, n_results, what, got, want);
    n_errors++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // schedule building
  // ---------------------------------------------------------------------------

  function automatic pidl_pkg::record_t rand_record();
    pidl_pkg::record_t rec;
    for (int w = 0; w < 4; w++) rec.name[w] = {$urandom, $urandom};
    rec.qty   = 16'($urandom);
    rec.day   = 5'($urandom_range(0, 31));
    rec.month = 4'($urandom_range(0, 15));
    rec.year  = 14'($urandom_range(0, 16383));
    return rec;
  endfunction

  task automatic queue_cmd(input logic [2:0] m, input logic [3:0] p,
                           input pidl_pkg::record_t rec);
    sched_op_t op;
    op = '0;
    op.kind = OP_CMD;
    op.cmd.mode = m;
    op.cmd.pos = p;
    op.cmd.rec = rec;
    op_queue.push_back(op);
  endtask

  task automatic queue_cap(input logic [3:0] cap);
    sched_op_t op;
    op = '0;
    op.kind = OP_CAP;
    op.cap = cap;
    op_queue.push_back(op);
  endtask

  task automatic queue_settle();
    sched_op_t op;
    op = '0;
    op.kind = OP_SETTLE;
    op_queue.push_back(op);
  endtask

  // random command: mostly positions from 1 to one past the store depth, some anywhere
  task automatic queue_random_cmd();
    int pick;
    logic [2:0] m;
    logic [3:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 25) m = pidl_pkg::MODE_PUSH;
    else if (pick < 45) m = pidl_pkg::MODE_INS;
    else if (pick < 60) m = pidl_pkg::MODE_POP;
    else if (pick < 75) m = pidl_pkg::MODE_DEQ;
    else if (pick < 97) m = pidl_pkg::MODE_REM;
    else m = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    if ($urandom_range(0, 99) < 80) p = 4'($urandom_range(1, pidl_pkg::STORE_DEPTH_DEF + 1));
    else p = 4'($urandom_range(0, 15));
    queue_cmd(m, p, rand_record());
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents commands and capacity writes at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      // item taken at this edge: predict its reply
      if (start && !busy) begin
        apply_list_op(cur_cmd);
        n_cmds++;
      end
      // quiet means nothing presented, nothing written and nothing owed
      if (start || cfg_we || predicted_replies.size() != 0) quiet_cycles = 0;
      else quiet_cycles++;
      // a command held against busy stays as it is
      if (!(start && busy)) begin
        drv_start = 1'b0;
        drv_we = 1'b0;
        if (op_queue.size() != 0) begin
          head_op = op_queue[0];
          case (head_op.kind)
            OP_CMD: begin
              // random gaps, except for one long burst in the middle
              gap_now = (n_cmds < BURST_FIRST || n_cmds >= BURST_LAST) &&
                        ($urandom_range(0, 99) < GAP_PCT);
              if (!gap_now) begin
                head_op = op_queue.pop_front();
                cur_cmd = head_op.cmd;
                drv_start = 1'b1;
              end
            end
            OP_CAP: begin
              // capacity changes only with the list at rest
              if (quiet_cycles >= SETTLE_CYCLES) begin
                head_op = op_queue.pop_front();
                drv_we = 1'b1;
                cfg_data <= head_op.cap;
                cap_limit = head_op.cap;
                n_cap_writes++;
              end
            end
            default: begin
              if (quiet_cycles >= SETTLE_CYCLES) head_op = op_queue.pop_front();
            end
          endcase
        end
        start <= drv_start;
        cfg_we <= drv_we;
        if (drv_start) begin
          mode <= cur_cmd.mode;
          position <= cur_cmd.pos;
          name_word_0 <= cur_cmd.rec.name[0];
          name_word_1 <= cur_cmd.rec.name[1];
          name_word_2 <= cur_cmd.rec.name[2];
          name_word_3 <= cur_cmd.rec.name[3];
          quantity <= cur_cmd.rec.qty;
          expiry_day <= cur_cmd.rec.day;
          expiry_month <= cur_cmd.rec.month;
          expiry_year <= cur_cmd.rec.year;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done cycle is one reply, checked against the oldest prediction
  // ---------------------------------------------------------------------------

  list_reply_t want_reply;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch("arrived with nothing outstanding", 64'(status), 64'(entry_count));
      end else begin
        want_reply = predicted_replies.pop_front();
        status_seen[want_reply.status]++;
        check_field("status", 64'(status), 64'(want_reply.status));
        check_field("entry_count", 64'(entry_count), 64'(want_reply.count));
        check_field("out_name_0", out_name_0, want_reply.rec.name[0]);
        check_field("out_name_1", out_name_1, want_reply.rec.name[1]);
        check_field("out_name_2", out_name_2, want_reply.rec.name[2]);
        check_field("out_name_3", out_name_3, want_reply.rec.name[3]);
        check_field("out_quantity", 64'(out_quantity), 64'(want_reply.rec.qty));
        check_field("out_day", 64'(out_day), 64'(want_reply.rec.day));
        check_field("out_month", 64'(out_month), 64'(want_reply.rec.month));
        check_field("out_year", 64'(out_year), 64'(want_reply.rec.year));
      end
      n_results++;
    end
  end

  // watchdog: too long with no item taken, no reply and no write means a hang
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d cycles without progress, %0d replies outstanding",
               idle_cycles, predicted_replies.size());
      $display("FAIL positional_insert_delete_list_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [3:0] phase_caps [0:9];
    int n_phase;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mode = '0;
    position = '0;
    name_word_0 = '0;
    name_word_1 = '0;
    name_word_2 = '0;
    name_word_3 = '0;
    quantity = '0;
    expiry_day = '0;
    expiry_month = '0;
    expiry_year = '0;

    // directed part at the reset capacity of five
    // removals and bad inserts on an empty list
    queue_cmd(pidl_pkg::MODE_POP, 4'd1, rand_record());
    queue_cmd(pidl_pkg::MODE_DEQ, 4'd1, rand_record());
    queue_cmd(pidl_pkg::MODE_REM, 4'd1, rand_record());     // empty wins over position
    queue_cmd(pidl_pkg::MODE_INS, 4'd0, rand_record());     // position zero
    queue_cmd(pidl_pkg::MODE_INS, 4'd2, rand_record());     // one past count plus one
    // fill to the limit with extreme and random records
    queue_cmd(pidl_pkg::MODE_INS, 4'd1, '1);
    queue_cmd(pidl_pkg::MODE_PUSH, 4'd15, '0);
    queue_cmd(pidl_pkg::MODE_INS, 4'd3, rand_record());     // insert at count plus one
    queue_cmd(pidl_pkg::MODE_INS, 4'd2, rand_record());     // shift the middle up
    queue_cmd(pidl_pkg::MODE_PUSH, 4'd0, rand_record());
    queue_cmd(pidl_pkg::MODE_PUSH, 4'd0, rand_record());    // full
    queue_cmd(pidl_pkg::MODE_INS, 4'd15, rand_record());    // full wins over position
    queue_cmd(MODE_UNUSED_FIRST, 4'd1, rand_record());
    queue_cmd(MODE_UNUSED_LAST, 4'd15, '1);
    // bad removal positions, then every kind of removal
    queue_cmd(pidl_pkg::MODE_REM, 4'd0, rand_record());
    queue_cmd(pidl_pkg::MODE_REM, 4'd6, rand_record());
    queue_cmd(pidl_pkg::MODE_REM, 4'd15, rand_record());
    queue_cmd(pidl_pkg::MODE_REM, 4'd3, rand_record());
    queue_cmd(pidl_pkg::MODE_DEQ, 4'd0, rand_record());
    queue_cmd(pidl_pkg::MODE_POP, 4'd0, rand_record());
    // a limit above the store depth is capped at the depth
    queue_cap(4'd15);
    for (int i = 0; i < 6; i++) queue_cmd(pidl_pkg::MODE_PUSH, 4'd0, rand_record());
    queue_cmd(pidl_pkg::MODE_PUSH, 4'd0, rand_record());

    // random phases; lower limits after full lists leave the count above the limit
    phase_caps = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd9, 4'd6, 4'd2, 4'd12, 4'd4};
    for (int ph = 0; ph < 10; ph++) begin
      queue_cap(phase_caps[ph]);
      n_phase = (phase_caps[ph] == 4'd0) ? ZERO_CAP_ITEMS : PHASE_ITEMS;
      for (int i = 0; i < n_phase; i++) begin
        // sender waits for every reply once in a while
        if (i == n_phase / 2 && ph % 3 == 0) queue_settle();
        queue_random_cmd();
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // wait for the schedule to run dry and every reply to come back
    while (op_queue.size() != 0 || start || n_results < n_cmds) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_replies.size() != 0)
      report_mismatch("never arrived, count left", 64'(predicted_replies.size()), 64'd0);

    $display("covered %0d list commands under %0d capacity writes, %0d replies checked",
             n_cmds, n_cap_writes, n_results);
    $display("reply mix: ok %0d, full %0d, empty %0d, bad position %0d",
             status_seen[pidl_pkg::ST_OK], status_seen[pidl_pkg::ST_FULL],
             status_seen[pidl_pkg::ST_EMPTY], status_seen[pidl_pkg::ST_BADPOS]);
    if (n_errors == 0) begin
      $display("PASS positional_insert_delete_list_unit");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL positional_insert_delete_list_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/pidl_ctrl.sv
rtl/positional_insert_delete_list_unit.sv
sim/tb_positional_insert_delete_list_unit.sv
